FILE: hw/rtl/hgs_pkg.sv
// ----------------------------------------------------------------------------
// hgs_pkg: shared types and constants of the hexapod gait sequencer
// Command codes, register map, configuration and queued command types.
// ----------------------------------------------------------------------------
package hgs_pkg;

    localparam int CHANNELS_DEF   = 12;
    localparam int PULSE_BITS_DEF = 12;

    localparam int FUNC_W    = 3;
    localparam int LEG_W     = 3;
    localparam int MASK_W    = 6;
    localparam int OFS_W     = 12;
    localparam int HOLD_W    = 11;
    localparam int NEUTRAL_W = 12;
    localparam int TRIM_W    = 48;
    localparam int REV_W     = 12;
    localparam int AMT_W     = 11;

    localparam int IN_DATA_W  = 40;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [HOLD_W-1:0] HOLD_SHORT  = 11'd60;
    localparam logic [HOLD_W-1:0] HOLD_MEDIUM = 11'd100;
    localparam logic [HOLD_W-1:0] HOLD_HOME   = 11'd2000;

    localparam logic [NEUTRAL_W-1:0] NEUTRAL_RST   = 12'd1500;
    localparam logic [TRIM_W-1:0]    TRIM_LOW_RST  = 48'd226500402012752;
    localparam logic [TRIM_W-1:0]    TRIM_HIGH_RST = 48'd109954618904576;
    localparam logic [REV_W-1:0]     REVERSE_RST   = 12'hCCC;
    localparam logic [AMT_W-1:0]     WAVE_LIFT_RST     = 11'd600;
    localparam logic [AMT_W-1:0]     WAVE_STRIDE_RST   = 11'd100;
    localparam logic [AMT_W-1:0]     TRIPOD_LIFT_RST   = 11'd800;
    localparam logic [AMT_W-1:0]     TRIPOD_STRIDE_RST = 11'd400;

    typedef enum logic [FUNC_W-1:0] {
        FN_HOME   = 3'd0,
        FN_WAVE   = 3'd1,
        FN_RIPPLE = 3'd2,
        FN_TRIPOD = 3'd3,
        FN_PLACE  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        REG_NEUTRAL       = 3'd0,
        REG_TRIM_LOW      = 3'd1,
        REG_TRIM_HIGH     = 3'd2,
        REG_REVERSE       = 3'd3,
        REG_WAVE_LIFT     = 3'd4,
        REG_WAVE_STRIDE   = 3'd5,
        REG_TRIPOD_LIFT   = 3'd6,
        REG_TRIPOD_STRIDE = 3'd7
    } t_reg;

    typedef struct packed {
        logic [NEUTRAL_W-1:0] neutral_pulse;
        logic [TRIM_W-1:0]    trim_low;
        logic [TRIM_W-1:0]    trim_high;
        logic [REV_W-1:0]     reverse_mask;
        logic [AMT_W-1:0]     wave_lift;
        logic [AMT_W-1:0]     wave_stride;
        logic [AMT_W-1:0]     tripod_lift;
        logic [AMT_W-1:0]     tripod_stride;
    } t_cfg;

    typedef struct packed {
        t_func                    func;
        logic [LEG_W-1:0]         leg;
        logic [MASK_W-1:0]        fmask;
        logic signed [OFS_W-1:0]  coxa_ofs;
        logic signed [OFS_W-1:0]  tibia_ofs;
    } t_cmd;

endpackage

FILE: hw/rtl/hexapod_gait_sequencer.sv
// ----------------------------------------------------------------------------
// hexapod_gait_sequencer: six-leg servo gait sequencer
// A command transfer goes into the queue; execution loads it while idle and registers each result.
// Throughput: one result per cycle while the result side does not stall; a command
// occupies the execution side for one channel sweep per frame (one frame for home,
// three for the other commands), through the single per-channel update unit. Commands queue two deep.
// Reset: synchronous, active low; widths to 1500, registers to defaults.
// ----------------------------------------------------------------------------
module hexapod_gait_sequencer #(
    parameter int CHANNELS   = hgs_pkg::CHANNELS_DEF,
    parameter int PULSE_BITS = hgs_pkg::PULSE_BITS_DEF,
    localparam int CH_W       = $clog2(CHANNELS),
    localparam int OUT_DATA_W = ((CH_W + PULSE_BITS + hgs_pkg::HOLD_W + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // leg, forward_mask, coxa_ofs, tibia_ofs, zero pad
    input  logic [hgs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [hgs_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // channel, pulse_width, hold_ms, zero pad
    output logic [OUT_DATA_W-1:0]            m_axis_tdata,
    // frame_end
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hgs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hgs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hgs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    hgs_pkg::t_cfg              w_cfg;
    hgs_pkg::t_cmd              w_push_cmd;
    hgs_pkg::t_cmd              w_head_cmd;
    logic                       w_push;
    logic                       w_full;
    logic                       w_pop;
    logic                       w_empty;
    logic [CH_W-1:0]            w_channel;
    logic [PULSE_BITS-1:0]      w_pulse;
    logic [hgs_pkg::HOLD_W-1:0] w_hold;
    logic                       w_frame_end;

    hgs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hgs_front #(
        .LEGS (CHANNELS / 2)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    hgs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    hgs_back #(
        .CHANNELS   (CHANNELS),
        .PULSE_BITS (PULSE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_empty   (w_empty),
        .i_q_cmd     (w_head_cmd),
        .o_q_pop     (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_channel   (w_channel),
        .o_pulse     (w_pulse),
        .o_hold      (w_hold),
        .o_frame_end (w_frame_end),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_W'({w_hold, w_pulse, w_channel});
    assign m_axis_tuser = w_frame_end;

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("command end not on a frame end");

    a_frame_end_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> w_channel == CH_W'(CHANNELS - 1))
        else $error("frame end on wrong channel");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=>
        m_axis_tvalid && (w_channel == CH_W'($past(w_channel) + 1'b1)))
        else $error("frame interrupted or channel skipped");

endmodule

FILE: hw/rtl/hgs_cfg_regs.sv
// ----------------------------------------------------------------------------
// hgs_cfg_regs: APB configuration registers
// Eight registers at 8-byte spacing, zero-wait writes and reads.
// ----------------------------------------------------------------------------
module hgs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hgs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hgs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hgs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output hgs_pkg::t_cfg                    o_cfg
);

    hgs_pkg::t_cfg r_cfg;
    hgs_pkg::t_reg w_idx;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_idx  = hgs_pkg::t_reg'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_pulse <= hgs_pkg::NEUTRAL_RST;
            r_cfg.trim_low      <= hgs_pkg::TRIM_LOW_RST;
            r_cfg.trim_high     <= hgs_pkg::TRIM_HIGH_RST;
            r_cfg.reverse_mask  <= hgs_pkg::REVERSE_RST;
            r_cfg.wave_lift     <= hgs_pkg::WAVE_LIFT_RST;
            r_cfg.wave_stride   <= hgs_pkg::WAVE_STRIDE_RST;
            r_cfg.tripod_lift   <= hgs_pkg::TRIPOD_LIFT_RST;
            r_cfg.tripod_stride <= hgs_pkg::TRIPOD_STRIDE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                hgs_pkg::REG_NEUTRAL: begin
                    r_cfg.neutral_pulse <= pwdata[hgs_pkg::NEUTRAL_W-1:0];
                end
                hgs_pkg::REG_TRIM_LOW: begin
                    r_cfg.trim_low <= pwdata[hgs_pkg::TRIM_W-1:0];
                end
                hgs_pkg::REG_TRIM_HIGH: begin
                    r_cfg.trim_high <= pwdata[hgs_pkg::TRIM_W-1:0];
                end
                hgs_pkg::REG_REVERSE: begin
                    r_cfg.reverse_mask <= pwdata[hgs_pkg::REV_W-1:0];
                end
                hgs_pkg::REG_WAVE_LIFT: begin
                    r_cfg.wave_lift <= pwdata[hgs_pkg::AMT_W-1:0];
                end
                hgs_pkg::REG_WAVE_STRIDE: begin
                    r_cfg.wave_stride <= pwdata[hgs_pkg::AMT_W-1:0];
                end
                hgs_pkg::REG_TRIPOD_LIFT: begin
                    r_cfg.tripod_lift <= pwdata[hgs_pkg::AMT_W-1:0];
                end
                hgs_pkg::REG_TRIPOD_STRIDE: begin
                    r_cfg.tripod_stride <= pwdata[hgs_pkg::AMT_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            hgs_pkg::REG_NEUTRAL:       prdata = hgs_pkg::APB_DATA_W'(r_cfg.neutral_pulse);
            hgs_pkg::REG_TRIM_LOW:      prdata = hgs_pkg::APB_DATA_W'(r_cfg.trim_low);
            hgs_pkg::REG_TRIM_HIGH:     prdata = hgs_pkg::APB_DATA_W'(r_cfg.trim_high);
            hgs_pkg::REG_REVERSE:       prdata = hgs_pkg::APB_DATA_W'(r_cfg.reverse_mask);
            hgs_pkg::REG_WAVE_LIFT:     prdata = hgs_pkg::APB_DATA_W'(r_cfg.wave_lift);
            hgs_pkg::REG_WAVE_STRIDE:   prdata = hgs_pkg::APB_DATA_W'(r_cfg.wave_stride);
            hgs_pkg::REG_TRIPOD_LIFT:   prdata = hgs_pkg::APB_DATA_W'(r_cfg.tripod_lift);
            hgs_pkg::REG_TRIPOD_STRIDE: prdata = hgs_pkg::APB_DATA_W'(r_cfg.tripod_stride);
        endcase
    end

endmodule

FILE: hw/rtl/hgs_front.sv
// ----------------------------------------------------------------------------
// hgs_front: command intake
// Takes commands off the input stream, drops ignored ones, forwards the rest.
// ----------------------------------------------------------------------------
module hgs_front #(
    parameter int LEGS = hgs_pkg::CHANNELS_DEF / 2
) (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // leg, forward_mask, coxa_ofs, tibia_ofs, zero pad
    input  logic [hgs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic [hgs_pkg::FUNC_W-1:0]      s_axis_tuser,
    input  logic                            i_q_full,
    output logic                            o_push,
    output hgs_pkg::t_cmd                   o_cmd
);

    logic          w_take;
    logic          w_keep;
    hgs_pkg::t_func w_func;

    assign s_axis_tready = !i_q_full;
    assign w_take        = s_axis_tvalid & s_axis_tready;
    assign w_func        = hgs_pkg::t_func'(s_axis_tuser);

    always_comb begin
        unique case (w_func) inside
            hgs_pkg::FN_HOME, hgs_pkg::FN_TRIPOD: begin
                w_keep = 1'b1;
            end
            hgs_pkg::FN_WAVE, hgs_pkg::FN_RIPPLE, hgs_pkg::FN_PLACE: begin
                w_keep = ({5'd0, s_axis_tdata[2:0]} < 8'(LEGS));
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push          = w_take & w_keep;
    assign o_cmd.func      = w_func;
    assign o_cmd.leg       = s_axis_tdata[2:0];
    assign o_cmd.fmask     = s_axis_tdata[8:3];
    assign o_cmd.coxa_ofs  = s_axis_tdata[20:9];
    assign o_cmd.tibia_ofs = s_axis_tdata[32:21];

endmodule

FILE: hw/rtl/hgs_cmd_queue.sv
// ----------------------------------------------------------------------------
// hgs_cmd_queue: command queue
// Short FIFO between intake and execution.
// ----------------------------------------------------------------------------
module hgs_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hgs_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output hgs_pkg::t_cmd  o_cmd
);

    localparam int DEPTH = hgs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hgs_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/hgs_back.sv
// ----------------------------------------------------------------------------
// hgs_back: command execution
// Sweeps the channels once per frame through one shared update unit,
// writes each new width back and registers it as a result.
// ----------------------------------------------------------------------------
module hgs_back #(
    parameter int CHANNELS   = hgs_pkg::CHANNELS_DEF,
    parameter int PULSE_BITS = hgs_pkg::PULSE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hgs_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_empty,
    input  hgs_pkg::t_cmd                   i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [$clog2(CHANNELS)-1:0]     o_channel,
    output logic [PULSE_BITS-1:0]           o_pulse,
    output logic [hgs_pkg::HOLD_W-1:0]      o_hold,
    output logic                            o_frame_end,
    output logic                            o_last
);

    localparam int CH_W      = $clog2(CHANNELS);
    localparam int BASE_W    = (PULSE_BITS > hgs_pkg::NEUTRAL_W) ? PULSE_BITS
                                                                 : hgs_pkg::NEUTRAL_W;
    localparam int SUM_W     = BASE_W + 3;
    localparam int PULSE_MAX = (1 << PULSE_BITS) - 1;
    localparam int TRIM_CH   = 12;

    localparam logic signed [SUM_W-1:0] SUM_MAX   = SUM_W'(PULSE_MAX);
    localparam logic [PULSE_BITS-1:0]   SERVO_RST = PULSE_BITS'(1500);

    localparam logic [1:0] PH_LIFT  = 2'd0;
    localparam logic [1:0] PH_SWING = 2'd1;
    localparam logic [1:0] PH_SET   = 2'd2;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                    r_state;
    hgs_pkg::t_cmd             r_cmd;
    logic [1:0]                r_phase;
    logic [CH_W-1:0]           r_ch;
    logic [PULSE_BITS-1:0]     r_servo [CHANNELS];
    logic                      r_valid;
    logic [CH_W-1:0]           r_channel;
    logic [PULSE_BITS-1:0]     r_pulse;
    logic [hgs_pkg::HOLD_W-1:0] r_hold;
    logic                      r_frame_end;
    logic                      r_last;

    logic [7:0]                w_ch8;
    logic [7:0]                w_leg8;
    logic                      w_tib;
    logic                      w_sel;
    logic                      w_mbit;
    logic [PULSE_BITS-1:0]     w_cur;
    logic                      w_upd;
    logic                      w_from_servo;
    logic signed [SUM_W-1:0]   w_amt;
    logic [hgs_pkg::HOLD_W-1:0] w_hold;
    logic signed [7:0]         w_trim;
    logic                      w_neg;
    logic signed [SUM_W-1:0]   w_amt_s;
    logic signed [SUM_W-1:0]   w_base;
    logic signed [SUM_W-1:0]   w_sum;
    logic [PULSE_BITS-1:0]     w_sat;
    logic [PULSE_BITS-1:0]     w_new;
    logic                      w_last_ch;
    logic [1:0]                w_final_ph;
    logic                      w_adv;

    assign w_ch8  = 8'(r_ch);
    assign w_leg8 = w_ch8 >> 1;
    assign w_tib  = r_ch[0];
    assign w_sel  = (w_leg8 == {5'd0, r_cmd.leg});
    assign w_mbit = (w_leg8 < 8'd6) && r_cmd.fmask[w_leg8[2:0]];
    assign w_cur  = r_servo[r_ch];

    // per-channel rule of the current frame
    always_comb begin
        w_upd        = 1'b0;
        w_from_servo = 1'b0;
        w_amt        = '0;
        w_hold       = hgs_pkg::HOLD_SHORT;
        unique case (r_cmd.func) inside
            hgs_pkg::FN_HOME: begin
                w_upd  = 1'b1;
                w_hold = hgs_pkg::HOLD_HOME;
            end
            hgs_pkg::FN_WAVE, hgs_pkg::FN_RIPPLE: begin
                case (r_phase)
                    PH_LIFT: begin
                        w_upd = w_tib && w_sel;
                        w_amt = SUM_W'(i_cfg.wave_lift);
                    end
                    PH_SWING: begin
                        w_upd = !w_tib;
                        if (w_sel) begin
                            w_amt = (r_cmd.func == hgs_pkg::FN_WAVE)
                                  ? SUM_W'(i_cfg.wave_stride) : '0;
                        end else begin
                            w_from_servo = 1'b1;
                            w_amt        = -SUM_W'(i_cfg.wave_stride);
                        end
                        w_hold = (r_cmd.func == hgs_pkg::FN_WAVE)
                               ? hgs_pkg::HOLD_MEDIUM : hgs_pkg::HOLD_SHORT;
                    end
                    default: begin
                        w_upd = w_tib && w_sel;
                    end
                endcase
            end
            hgs_pkg::FN_TRIPOD: begin
                w_hold = hgs_pkg::HOLD_MEDIUM;
                case (r_phase)
                    PH_LIFT: begin
                        w_upd = w_tib && w_mbit;
                        w_amt = SUM_W'(i_cfg.tripod_lift);
                    end
                    PH_SWING: begin
                        w_upd  = !w_tib;
                        w_amt  = w_mbit ? SUM_W'(i_cfg.tripod_stride)
                                        : -SUM_W'(i_cfg.tripod_stride);
                        w_hold = hgs_pkg::HOLD_SHORT;
                    end
                    default: begin
                        w_upd = w_tib && w_mbit;
                    end
                endcase
            end
            hgs_pkg::FN_PLACE: begin
                case (r_phase)
                    PH_LIFT: begin
                        w_upd = w_tib && w_sel;
                        w_amt = SUM_W'(i_cfg.wave_lift);
                    end
                    PH_SWING: begin
                        w_upd = !w_tib && w_sel;
                        w_amt = SUM_W'(r_cmd.coxa_ofs);
                    end
                    default: begin
                        w_upd = w_tib && w_sel;
                        w_amt = SUM_W'(r_cmd.tibia_ofs);
                    end
                endcase
            end
            default: begin
                w_upd = 1'b0;
            end
        endcase
    end

    // trim and direction of the current channel
    always_comb begin
        logic [7:0] k;
        k = w_ch8 - 8'd6;
        if (w_ch8 < 8'd6) begin
            w_trim = $signed(i_cfg.trim_low[w_ch8[2:0]*8 +: 8]);
        end else if (w_ch8 < 8'(TRIM_CH)) begin
            w_trim = $signed(i_cfg.trim_high[k[2:0]*8 +: 8]);
        end else begin
            w_trim = '0;
        end
        w_neg = (w_ch8 < 8'(TRIM_CH)) && i_cfg.reverse_mask[w_ch8[3:0]];
    end

    assign w_amt_s = w_neg ? -w_amt : w_amt;
    assign w_base  = w_from_servo ? SUM_W'(w_cur)
                                  : SUM_W'(i_cfg.neutral_pulse) + SUM_W'(w_trim);
    assign w_sum   = w_base + w_amt_s;

    always_comb begin
        if (w_sum < 0) begin
            w_sat = '0;
        end else if (w_sum > SUM_MAX) begin
            w_sat = PULSE_BITS'(PULSE_MAX);
        end else begin
            w_sat = w_sum[PULSE_BITS-1:0];
        end
    end

    assign w_new      = w_upd ? w_sat : w_cur;
    assign w_last_ch  = (r_ch == CH_W'(CHANNELS - 1));
    assign w_final_ph = (r_cmd.func == hgs_pkg::FN_HOME) ? PH_LIFT : PH_SET;
    assign w_adv      = (r_state == ST_RUN) && (!r_valid || i_ready);
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_phase <= PH_LIFT;
            r_ch    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_servo[i] <= SERVO_RST;
            end
        end else begin
            if (w_adv) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_q_cmd;
                        r_phase <= PH_LIFT;
                        r_ch    <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_adv) begin
                        r_servo[r_ch] <= w_new;
                        r_channel     <= r_ch;
                        r_pulse       <= w_new;
                        r_hold        <= w_hold;
                        r_frame_end   <= w_last_ch;
                        r_last        <= w_last_ch && (r_phase == w_final_ph);
                        if (w_last_ch) begin
                            r_ch <= '0;
                            if (r_phase == w_final_ph) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_phase <= r_phase + 2'd1;
                            end
                        end else begin
                            r_ch <= r_ch + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_channel   = r_channel;
    assign o_pulse     = r_pulse;
    assign o_hold      = r_hold;
    assign o_frame_end = r_frame_end;
    assign o_last      = r_last;

endmodule

FILE: tb/hgs_frame_checker.sv
// ----------------------------------------------------------------------------
// hgs_frame_checker: scoreboard for the hexapod gait sequencer
// Tracks APB register writes and accepted commands, keeps its own copy of
// the twelve servo widths, queues the expected channel transfers and checks
// every result transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module hgs_frame_checker #(
    parameter int RES_DATA_W = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  logic                           i_cmd_ready,
    input  logic [hgs_pkg::IN_DATA_W-1:0]  i_cmd_data,
    input  logic [hgs_pkg::FUNC_W-1:0]     i_cmd_func,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [RES_DATA_W-1:0]          i_res_data,
    input  logic                           i_res_frame_end,
    input  logic                           i_res_last,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [hgs_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [hgs_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS = hgs_pkg::CHANNELS_DEF;
    localparam int LEGS     = CHANNELS / 2;
    localparam int PW       = hgs_pkg::PULSE_BITS_DEF;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int PW_MAX   = (1 << PW) - 1;
    localparam int HOLD_W   = hgs_pkg::HOLD_W;

    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic [PW-1:0]     pulse;
        logic [HOLD_W-1:0] hold;
        logic              frame_end;
        logic              last;
    } t_servo_beat;

    hgs_pkg::t_cfg shadow_cfg;
    logic [PW-1:0] servo_w [CHANNELS];
    t_servo_beat   expected_beats [$];

    function automatic int clip_pulse(int v);
        if (v < 0) return 0;
        if (v > PW_MAX) return PW_MAX;
        return v;
    endfunction

    function automatic int trim_of(int ch);
        logic [7:0] b;
        if (ch < 6) b = shadow_cfg.trim_low[8*ch +: 8];
        else if (ch < 12) b = shadow_cfg.trim_high[8*(ch-6) +: 8];
        else b = 8'd0;
        return int'($signed(b));
    endfunction

    function automatic int sign_of(int ch);
        if (ch < 12 && shadow_cfg.reverse_mask[ch]) return -1;
        return 1;
    endfunction

    function automatic logic [PW-1:0] aim(int ch, int amount);
        return PW'(clip_pulse(int'(shadow_cfg.neutral_pulse) + trim_of(ch)
                              + amount * sign_of(ch)));
    endfunction

    task automatic emit_frame(logic [HOLD_W-1:0] hold, logic fin);
        t_servo_beat b;
        for (int c = 0; c < CHANNELS; c++) begin
            b.chan      = CH_W'(c);
            b.pulse     = servo_w[c];
            b.hold      = hold;
            b.frame_end = (c == CHANNELS - 1);
            b.last      = fin && (c == CHANNELS - 1);
            expected_beats.push_back(b);
        end
    endtask

    task automatic predict_gait(logic [hgs_pkg::FUNC_W-1:0] fn,
                                logic [hgs_pkg::LEG_W-1:0] leg,
                                logic [hgs_pkg::MASK_W-1:0] fmask,
                                logic signed [hgs_pkg::OFS_W-1:0] cofs,
                                logic signed [hgs_pkg::OFS_W-1:0] tofs);
        int cx, tb, amt, lift, stride;
        cx = 2 * leg;
        tb = cx + 1;
        if (fn == hgs_pkg::FN_HOME) begin
            for (int c = 0; c < CHANNELS; c++) servo_w[c] = aim(c, 0);
            emit_frame(hgs_pkg::HOLD_HOME, 1'b1);
        end else if (fn == hgs_pkg::FN_TRIPOD) begin
            lift   = int'(shadow_cfg.tripod_lift);
            stride = int'(shadow_cfg.tripod_stride);
            for (int l = 0; l < LEGS; l++)
                if (fmask[l]) servo_w[2*l+1] = aim(2*l+1, lift);
            emit_frame(hgs_pkg::HOLD_MEDIUM, 1'b0);
            for (int l = 0; l < LEGS; l++) begin
                amt = fmask[l] ? stride : -stride;
                servo_w[2*l] = aim(2*l, amt);
            end
            emit_frame(hgs_pkg::HOLD_SHORT, 1'b0);
            for (int l = 0; l < LEGS; l++)
                if (fmask[l]) servo_w[2*l+1] = aim(2*l+1, 0);
            emit_frame(hgs_pkg::HOLD_MEDIUM, 1'b1);
        end else if (fn == hgs_pkg::FN_PLACE && leg < LEGS) begin
            servo_w[tb] = aim(tb, int'(shadow_cfg.wave_lift));
            emit_frame(hgs_pkg::HOLD_SHORT, 1'b0);
            servo_w[cx] = aim(cx, int'(cofs));
            emit_frame(hgs_pkg::HOLD_SHORT, 1'b0);
            servo_w[tb] = aim(tb, int'(tofs));
            emit_frame(hgs_pkg::HOLD_SHORT, 1'b1);
        end else if ((fn == hgs_pkg::FN_WAVE || fn == hgs_pkg::FN_RIPPLE) && leg < LEGS) begin
            stride = int'(shadow_cfg.wave_stride);
            servo_w[tb] = aim(tb, int'(shadow_cfg.wave_lift));
            emit_frame(hgs_pkg::HOLD_SHORT, 1'b0);
            servo_w[cx] = aim(cx, (fn == hgs_pkg::FN_WAVE) ? stride : 0);
            // remaining coxas drift back by one stride, saturating
            for (int l = 0; l < LEGS; l++)
                if (2*l != cx)
                    servo_w[2*l] = PW'(clip_pulse(int'(servo_w[2*l]) - stride * sign_of(2*l)));
            emit_frame((fn == hgs_pkg::FN_WAVE) ? hgs_pkg::HOLD_MEDIUM : hgs_pkg::HOLD_SHORT,
                       1'b0);
            servo_w[tb] = aim(tb, 0);
            emit_frame(hgs_pkg::HOLD_SHORT, 1'b1);
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_servo_beat want;
        if (!i_rst_n) begin
            shadow_cfg.neutral_pulse = hgs_pkg::NEUTRAL_RST;
            shadow_cfg.trim_low      = hgs_pkg::TRIM_LOW_RST;
            shadow_cfg.trim_high     = hgs_pkg::TRIM_HIGH_RST;
            shadow_cfg.reverse_mask  = hgs_pkg::REVERSE_RST;
            shadow_cfg.wave_lift     = hgs_pkg::WAVE_LIFT_RST;
            shadow_cfg.wave_stride   = hgs_pkg::WAVE_STRIDE_RST;
            shadow_cfg.tripod_lift   = hgs_pkg::TRIPOD_LIFT_RST;
            shadow_cfg.tripod_stride = hgs_pkg::TRIPOD_STRIDE_RST;
            for (int c = 0; c < CHANNELS; c++) servo_w[c] = PW'(1500);
            expected_beats.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result transfer: channel %0d, pulse %0d",
                           i_res_data[CH_W-1:0], i_res_data[CH_W +: PW]);
                    o_fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("channel", 16'(want.chan), 16'(i_res_data[CH_W-1:0]));
                    check_field("pulse_width", 16'(want.pulse), 16'(i_res_data[CH_W +: PW]));
                    check_field("hold_ms", 16'(want.hold), 16'(i_res_data[CH_W+PW +: HOLD_W]));
                    check_field("frame_end", 16'(want.frame_end), 16'(i_res_frame_end));
                    check_field("last", 16'(want.last), 16'(i_res_last));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (hgs_pkg::t_reg'(i_paddr[hgs_pkg::APB_ADDR_W-1 -: 3]))
                    hgs_pkg::REG_NEUTRAL:
                        shadow_cfg.neutral_pulse = i_pwdata[hgs_pkg::NEUTRAL_W-1:0];
                    hgs_pkg::REG_TRIM_LOW:
                        shadow_cfg.trim_low = i_pwdata[hgs_pkg::TRIM_W-1:0];
                    hgs_pkg::REG_TRIM_HIGH:
                        shadow_cfg.trim_high = i_pwdata[hgs_pkg::TRIM_W-1:0];
                    hgs_pkg::REG_REVERSE:
                        shadow_cfg.reverse_mask = i_pwdata[hgs_pkg::REV_W-1:0];
                    hgs_pkg::REG_WAVE_LIFT:
                        shadow_cfg.wave_lift = i_pwdata[hgs_pkg::AMT_W-1:0];
                    hgs_pkg::REG_WAVE_STRIDE:
                        shadow_cfg.wave_stride = i_pwdata[hgs_pkg::AMT_W-1:0];
                    hgs_pkg::REG_TRIPOD_LIFT:
                        shadow_cfg.tripod_lift = i_pwdata[hgs_pkg::AMT_W-1:0];
                    hgs_pkg::REG_TRIPOD_STRIDE:
                        shadow_cfg.tripod_stride = i_pwdata[hgs_pkg::AMT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready)
                predict_gait(i_cmd_func, i_cmd_data[2:0], i_cmd_data[8:3],
                             i_cmd_data[20:9], i_cmd_data[32:21]);
        end
        o_pending = expected_beats.size();
    end

endmodule

FILE: tb/hexapod_gait_sequencer_tb.sv
// ----------------------------------------------------------------------------
// hexapod_gait_sequencer_tb: stimulus and verdict for the gait sequencer
// Drives directed and random gait commands over several register settings,
// including both saturation extremes, with random gaps on the command side
// and random back-pressure on the result side. Checking is in the checker.
// ----------------------------------------------------------------------------
module hexapod_gait_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FUNC_W     = hgs_pkg::FUNC_W;
    localparam int LEG_W      = hgs_pkg::LEG_W;
    localparam int MASK_W     = hgs_pkg::MASK_W;
    localparam int OFS_W      = hgs_pkg::OFS_W;
    localparam int IN_DATA_W  = hgs_pkg::IN_DATA_W;
    localparam int APB_DATA_W = hgs_pkg::APB_DATA_W;
    localparam int APB_ADDR_W = hgs_pkg::APB_ADDR_W;
    localparam int RES_DATA_W = ((4 + hgs_pkg::PULSE_BITS_DEF + hgs_pkg::HOLD_W + 7) / 8) * 8;
    localparam int LEGS       = hgs_pkg::CHANNELS_DEF / 2;
    localparam logic [LEG_W-1:0]  LEG_MAX = '1;
    localparam logic [FUNC_W-1:0] FN_MAX  = '1;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;  // leg, forward_mask, coxa_ofs, tibia_ofs, pad
    logic [FUNC_W-1:0]     s_axis_tuser;  // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [RES_DATA_W-1:0] m_axis_tdata;  // channel, pulse_width, hold_ms, pad
    logic [0:0]            m_axis_tuser;  // frame_end
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int src_calm = 0;
    int snk_calm = 0;

    hexapod_gait_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hgs_frame_checker #(.RES_DATA_W(RES_DATA_W)) frame_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (s_axis_tvalid),
        .i_cmd_ready     (s_axis_tready),
        .i_cmd_data      (s_axis_tdata),
        .i_cmd_func      (s_axis_tuser),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_data      (m_axis_tdata),
        .i_res_frame_end (m_axis_tuser[0]),
        .i_res_last      (m_axis_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // occasional runs of back-to-back transfers between random gaps
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [APB_DATA_W-1:0] draw_amount();
        if ($urandom_range(0, 4) == 0) return APB_DATA_W'($urandom_range(0, 2047));
        return APB_DATA_W'($urandom_range(0, 900));
    endfunction

    task automatic write_reg(hgs_pkg::t_reg idx, logic [APB_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_cmd(logic [FUNC_W-1:0] fn, logic [LEG_W-1:0] leg,
                            logic [MASK_W-1:0] fmask, logic [OFS_W-1:0] cofs,
                            logic [OFS_W-1:0] tofs);
        int gap;
        gap = draw_gap(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= IN_DATA_W'({tofs, cofs, fmask, leg});
        s_axis_tuser  <= fn;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // drain all results and let any ignored command retire
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_cmd(hgs_pkg::FN_HOME, 0, 0, 0, 0);
        send_cmd(hgs_pkg::FN_WAVE, 0, 6'h3F, 12'h800, 12'h7FF);
        send_cmd(hgs_pkg::FN_WAVE, LEG_W'(LEGS - 1), 0, 0, 0);
        send_cmd(hgs_pkg::FN_RIPPLE, 2, 6'h2A, 12'hFFF, 12'h000);
        send_cmd(hgs_pkg::FN_RIPPLE, 3, 0, 0, 0);
        send_cmd(hgs_pkg::FN_TRIPOD, 0, 6'h15, 0, 0);
        send_cmd(hgs_pkg::FN_TRIPOD, 0, 6'h2A, 0, 0);
        send_cmd(hgs_pkg::FN_TRIPOD, LEG_MAX, 6'h00, 12'hFFF, 12'hFFF);
        send_cmd(hgs_pkg::FN_TRIPOD, LEG_W'(LEGS), 6'h3F, 0, 0);
        send_cmd(hgs_pkg::FN_PLACE, 1, 0, 12'h7FF, 12'h800);
        send_cmd(hgs_pkg::FN_PLACE, 4, 6'h3F, 12'h800, 12'h7FF);
        send_cmd(hgs_pkg::FN_PLACE, 0, 0, 0, 0);
        send_cmd(hgs_pkg::FN_PLACE, LEG_W'(LEGS - 1), 0, 12'hFFF, 12'h001);
        // leg out of range and unknown codes produce nothing
        send_cmd(hgs_pkg::FN_WAVE, LEG_W'(LEGS), 0, 0, 0);
        send_cmd(hgs_pkg::FN_RIPPLE, LEG_MAX, 6'h3F, 0, 0);
        send_cmd(hgs_pkg::FN_PLACE, LEG_W'(LEGS), 0, 12'h7FF, 12'h7FF);
        for (int f = int'(hgs_pkg::FN_PLACE) + 1; f <= int'(FN_MAX); f++)
            send_cmd(FUNC_W'(f), 0, 6'h3F, 12'hFFF, 12'hFFF);
        send_cmd(hgs_pkg::FN_WAVE, 1, 0, 0, 0);
        send_cmd(hgs_pkg::FN_HOME, LEG_MAX, 6'h3F, 12'hFFF, 12'hFFF);
    endtask

    task automatic run_random(int n);
        int done, pick;
        logic [FUNC_W-1:0] fn;
        logic [LEG_W-1:0]  leg;
        logic [OFS_W-1:0]  cofs, tofs;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(0, 99);
            leg  = LEG_W'($urandom_range(0, LEGS - 1));
            cofs = OFS_W'($urandom);
            tofs = OFS_W'($urandom);
            if (pick < 8) fn = hgs_pkg::FN_HOME;
            else if (pick < 30) fn = hgs_pkg::FN_WAVE;
            else if (pick < 50) fn = hgs_pkg::FN_RIPPLE;
            else if (pick < 72) fn = hgs_pkg::FN_TRIPOD;
            else if (pick < 94) fn = hgs_pkg::FN_PLACE;
            else if (pick < 97)
                fn = FUNC_W'($urandom_range(int'(hgs_pkg::FN_PLACE) + 1, int'(FN_MAX)));
            else begin
                case ($urandom_range(0, 2))
                    0: fn = hgs_pkg::FN_WAVE;
                    1: fn = hgs_pkg::FN_RIPPLE;
                    default: fn = hgs_pkg::FN_PLACE;
                endcase
                leg = LEG_W'($urandom_range(LEGS, int'(LEG_MAX)));
            end
            if (fn == hgs_pkg::FN_TRIPOD) leg = LEG_W'($urandom);
            if (fn == hgs_pkg::FN_PLACE && $urandom_range(0, 1) == 0) begin
                cofs = OFS_W'($urandom_range(0, 600) - 300);
                tofs = OFS_W'($urandom_range(0, 600) - 300);
            end
            send_cmd(fn, leg, MASK_W'($urandom), cofs, tofs);
            if (pick < 94) done++;
        end
    endtask

    task automatic program_random();
        write_reg(hgs_pkg::REG_NEUTRAL,
                  APB_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(1200, 1800)));
        write_reg(hgs_pkg::REG_TRIM_LOW, {$urandom, $urandom});
        write_reg(hgs_pkg::REG_TRIM_HIGH, {$urandom, $urandom});
        write_reg(hgs_pkg::REG_REVERSE, APB_DATA_W'($urandom));
        write_reg(hgs_pkg::REG_WAVE_LIFT, draw_amount());
        write_reg(hgs_pkg::REG_WAVE_STRIDE, draw_amount());
        write_reg(hgs_pkg::REG_TRIPOD_LIFT, draw_amount());
        write_reg(hgs_pkg::REG_TRIPOD_STRIDE, draw_amount());
    endtask

    task automatic program_extreme(logic [11:0] neutral, logic [7:0] trim, logic [11:0] rev);
        write_reg(hgs_pkg::REG_NEUTRAL, APB_DATA_W'(neutral));
        write_reg(hgs_pkg::REG_TRIM_LOW, APB_DATA_W'({6{trim}}));
        write_reg(hgs_pkg::REG_TRIM_HIGH, APB_DATA_W'({6{trim}}));
        write_reg(hgs_pkg::REG_REVERSE, APB_DATA_W'(rev));
        write_reg(hgs_pkg::REG_WAVE_LIFT, 2047);
        write_reg(hgs_pkg::REG_WAVE_STRIDE, 2047);
        write_reg(hgs_pkg::REG_TRIPOD_LIFT, 2047);
        write_reg(hgs_pkg::REG_TRIPOD_STRIDE, 2047);
    endtask

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap(snk_calm);
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(45);
        settle();
        program_extreme(12'hFFF, 8'h7F, 12'h000);
        run_directed();
        run_random(25);
        settle();
        program_extreme(12'h000, 8'h80, 12'hFFF);
        run_directed();
        run_random(25);
        for (int p = 0; p < 4; p++) begin
            settle();
            program_random();
            run_random(45);
        end
        settle();

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
